// ----- sv/pvb_pkg.sv -----
// ----------------------------------------------------------------------------
// pvb_pkg
// Types, codes and helper functions shared by the velocity blend files.
// ----------------------------------------------------------------------------
package pvb_pkg;

	// weighted product format
	localparam int unsigned WEIGHT_FRAC = 8;
	localparam int unsigned DT_FRAC     = 16;
	localparam int unsigned SUM_W       = 48;
	localparam int unsigned VEL_W       = 32;
	localparam int unsigned CFG_W       = 31;
	localparam int unsigned IDX_W       = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
	localparam logic [IDX_W-1:0] CFG_MAX_ACCEL = 2'd1;
	localparam logic [IDX_W-1:0] CFG_NEAR_ZERO = 2'd2;

	// reset values of the registers
	localparam logic [CFG_W-1:0] MAX_SPEED_RST = 31'd153600;
	localparam logic [CFG_W-1:0] MAX_ACCEL_RST = 31'd524288;

	// input request payload
	typedef struct packed {
		logic                      kind;
		logic signed [VEL_W-1:0]   vel_x;
		logic signed [VEL_W-1:0]   vel_y;
		logic signed [VEL_W-1:0]   vel_z;
		logic [15:0]               weight;
		logic                      last_of_layer;
		logic [15:0]               delta_time;
	} req_t;

	// result payload
	typedef struct packed {
		logic signed [VEL_W-1:0] new_vel_x;
		logic signed [VEL_W-1:0] new_vel_y;
		logic signed [VEL_W-1:0] new_vel_z;
	} rsp_t;

	// request kinds
	localparam logic KIND_CONTRIB = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WMUL,
		ST_WACC,
		ST_LOAD,
		ST_ACCEL,
		ST_LIMIT,
		ST_SHIFT,
		ST_SQMUL,
		ST_SQACC,
		ST_SQRT,
		ST_DECIDE,
		ST_SCMUL,
		ST_DLOAD,
		ST_DIV,
		ST_ADD,
		ST_OUT
	} pvb_state_t;

	// saturate a 50-bit sum to 48 bits
	function automatic logic signed [SUM_W-1:0] sat48(input logic signed [49:0] v);
		logic signed [49:0] hi;
		logic signed [49:0] lo;
		hi = 50'sh0_7FFF_FFFF_FFFF;
		lo = -hi - 50'sd1;
		if (v > hi) begin
			return hi[SUM_W-1:0];
		end else if (v < lo) begin
			return lo[SUM_W-1:0];
		end
		return v[SUM_W-1:0];
	endfunction

	// saturate a 50-bit sum to 32 bits
	function automatic logic signed [VEL_W-1:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -50'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[VEL_W-1:0];
	endfunction

	// magnitude of a 48-bit signed value
	function automatic logic [SUM_W-1:0] abs48(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
	endfunction

endpackage

// ----- sv/pvb_stream_if.sv -----
// ----------------------------------------------------------------------------
// pvb_stream_if
// Valid/ready channel carrying one payload per accepted request.
// ----------------------------------------------------------------------------
interface pvb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/prioritized_velocity_blend.sv -----
// ----------------------------------------------------------------------------
// prioritized_velocity_blend
// Prioritised truncated-sum steering with acceleration limit, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req carries weighted contributions (kind 0), grouped by layer in priority
//   order, then one end-of-tick request (kind 1) with the current velocity and
//   dt. rsp carries the applied velocity, at most one per tick.
//   cfg_we/cfg_index/cfg_data write max_speed, max_accel and near_zero_level;
//   write only while the block is idle.
// Timing:
//   req.ready is high only while the sequencer is idle; one request is worked
//   at a time. A contribution with a nonzero weight runs a multiply and an
//   accumulate for each axis. A layer close or an emitting end of tick runs
//   up to 17 shift steps, the squares, 32 root steps, and when scaling a
//   restoring divide for each axis, all on one shared 33x33
//   multiplier and one add/compare path. The root and divider loops dominate.
// Reset and stalls:
//   arst_n restores the register defaults and empties the tick. A result
//   waits in the rsp register; the block keeps taking contributions, and an
//   end of tick that has a new result holds until the old one is taken.
// ----------------------------------------------------------------------------
module prioritized_velocity_blend
	import pvb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	pvb_stream_if.sink              req,
	pvb_stream_if.source            rsp,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	pvb_state_t state_q, state_d;

	// configuration
	logic [CFG_W-1:0] max_speed_q, max_accel_q;
	logic [7:0]       near_zero_q;

	// tick state
	logic             layer_seen_q, budget_spent_q;
	logic [CFG_W-1:0] budget_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [VEL_W-1:0] tot_q [3];

	// latched request
	req_t             req_q;
	logic             tick_q;

	// vector working set
	logic signed [SUM_W-1:0] vec_q [3];
	logic [SUM_W-1:0]        abs_q [3];
	logic                    sh_q;
	logic [CFG_W-1:0]        lim_q;
	logic [1:0]              ax_q;
	logic [4:0]              cnt_q;
	logic [63:0]             x_q, r_q;
	logic [31:0]             rem_q, quo_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic                    accept, emit, spent_eff, any_big, last_ax;
	logic signed [VEL_W-1:0] vin [3];
	logic signed [32:0]      dif [3];
	logic signed [65:0]      wprod;
	logic [63:0]             bitv, rb;
	logic                    sq_ge;
	logic [32:0]             rp;
	logic                    dv_ge;
	logic [31:0]             quo_n;
	logic [31:0]             m_root;
	logic                    scale_now;

	function automatic logic near0(input logic signed [VEL_W-1:0] v,
			input logic [7:0] t);
		logic signed [32:0] tt;
		tt = 33'(t);
		return (33'(v) <= tt) && (33'(v) >= -tt);
	endfunction

	// request fields and derived terms
	always_comb begin
		vin[0]    = req.data.vel_x;
		vin[1]    = req.data.vel_y;
		vin[2]    = req.data.vel_z;
		accept    = req.valid && req.ready;
		spent_eff = layer_seen_q && budget_spent_q;
		for (int i = 0; i < 3; i++) begin
			dif[i] = 33'(tot_q[i]) - 33'(vin[i]);
		end
		emit = layer_seen_q &&
			!(near0(tot_q[0], near_zero_q) && near0(tot_q[1], near_zero_q) &&
			near0(tot_q[2], near_zero_q) && near0(vin[0], near_zero_q) &&
			near0(vin[1], near_zero_q) && near0(vin[2], near_zero_q));
		any_big = (abs_q[0][SUM_W-1:CFG_W] != '0) || (abs_q[1][SUM_W-1:CFG_W] != '0) ||
			(abs_q[2][SUM_W-1:CFG_W] != '0);
		last_ax = (ax_q == 2'd2);
		wprod   = prod_q >>> WEIGHT_FRAC;
		bitv    = 64'd1 << {cnt_q, 1'b0};
		rb      = r_q + bitv;
		sq_ge   = x_q >= rb;
		rp      = {rem_q, quo_q[31]};
		dv_ge   = rp >= {1'b0, r_q[31:0]};
		quo_n   = {quo_q[30:0], dv_ge};
		m_root  = r_q[31:0];
		scale_now = sh_q || (m_root > 32'(lim_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.data.kind == KIND_TICK) begin
						state_d = emit ? ST_ACCEL : ST_IDLE;
					end else if (spent_eff) begin
						state_d = ST_IDLE;
					end else if (req.data.weight != '0) begin
						state_d = ST_WMUL;
					end else if (req.data.last_of_layer) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_WMUL:  state_d = ST_WACC;
			ST_WACC: begin
				if (last_ax) begin
					state_d = req_q.last_of_layer ? ST_LOAD : ST_IDLE;
				end else begin
					state_d = ST_WMUL;
				end
			end
			ST_LOAD:  state_d = ST_SHIFT;
			ST_ACCEL: state_d = ST_LIMIT;
			ST_LIMIT: state_d = (prod_q[46:16] == '0) ? ST_ADD : ST_SHIFT;
			ST_SHIFT: state_d = any_big ? ST_SHIFT : ST_SQMUL;
			ST_SQMUL: state_d = ST_SQACC;
			ST_SQACC: state_d = last_ax ? ST_SQRT : ST_SQMUL;
			ST_SQRT:  state_d = (cnt_q == '0) ? ST_DECIDE : ST_SQRT;
			ST_DECIDE: begin
				if (!sh_q && m_root == '0 && !tick_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = scale_now ? ST_SCMUL : ST_ADD;
				end
			end
			ST_SCMUL: state_d = ST_DLOAD;
			ST_DLOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = last_ax ? ST_ADD : ST_SCMUL;
				end
			end
			ST_ADD: begin
				if (last_ax) begin
					state_d = tick_q ? ST_OUT : ST_IDLE;
				end
			end
			ST_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and multiplier operand selection
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_WMUL: begin
				mul_a = 33'(req_q.vel_x);
				if (ax_q == 2'd1) begin
					mul_a = 33'(req_q.vel_y);
				end else if (ax_q == 2'd2) begin
					mul_a = 33'(req_q.vel_z);
				end
				mul_b = $signed({17'd0, req_q.weight});
			end
			ST_ACCEL: begin
				mul_a = $signed({2'd0, max_accel_q});
				mul_b = $signed({17'd0, req_q.delta_time});
			end
			ST_SQMUL: begin
				mul_a = $signed({2'd0, abs_q[ax_q][CFG_W-1:0]});
				mul_b = $signed({2'd0, abs_q[ax_q][CFG_W-1:0]});
			end
			ST_SCMUL: begin
				mul_a = $signed({2'd0, abs_q[ax_q][CFG_W-1:0]});
				mul_b = $signed({2'd0, lim_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			max_speed_q    <= MAX_SPEED_RST;
			max_accel_q    <= MAX_ACCEL_RST;
			near_zero_q    <= '0;
			layer_seen_q   <= 1'b0;
			budget_spent_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_SPEED: max_speed_q <= cfg_data;
					CFG_MAX_ACCEL: max_accel_q <= cfg_data;
					CFG_NEAR_ZERO: near_zero_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && accept) begin
				if (req.data.kind == KIND_TICK) begin
					layer_seen_q   <= 1'b0;
					budget_spent_q <= 1'b0;
				end else if (!layer_seen_q) begin
					layer_seen_q   <= 1'b1;
					budget_spent_q <= 1'b0;
				end
			end
			if (state_q == ST_DECIDE && !tick_q && scale_now) begin
				budget_spent_q <= 1'b1;
			end
			if (state_q == ST_OUT && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				ax_q <= '0;
				sh_q <= 1'b0;
				if (accept) begin
					req_q <= req.data;
					if (req.data.kind == KIND_TICK) begin
						tick_q   <= 1'b1;
						budget_q <= max_speed_q;
						for (int i = 0; i < 3; i++) begin
							vec_q[i] <= SUM_W'(dif[i]);
							abs_q[i] <= abs48(SUM_W'(dif[i]));
							tot_q[i] <= vin[i];
							sum_q[i] <= '0;
						end
					end else begin
						tick_q <= 1'b0;
						if (!layer_seen_q) begin
							budget_q <= max_speed_q;
							for (int i = 0; i < 3; i++) begin
								tot_q[i] <= '0;
								sum_q[i] <= '0;
							end
						end
					end
				end
			end
			// accumulate the weighted product into the open layer
			ST_WACC: begin
				sum_q[ax_q] <= sat48(50'(sum_q[ax_q]) + 50'(wprod));
				ax_q        <= last_ax ? 2'd0 : ax_q + 2'd1;
			end
			// close the layer: take its sum against the budget
			ST_LOAD: begin
				lim_q <= budget_q;
				for (int i = 0; i < 3; i++) begin
					vec_q[i] <= sum_q[i];
					abs_q[i] <= abs48(sum_q[i]);
					sum_q[i] <= '0;
				end
			end
			// acceleration limit for this tick
			ST_LIMIT: begin
				lim_q <= prod_q[46:16];
				if (prod_q[46:16] == '0) begin
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= '0;
					end
				end
			end
			// common right shift until every part fits 31 bits
			ST_SHIFT: begin
				if (any_big) begin
					sh_q <= 1'b1;
					for (int i = 0; i < 3; i++) begin
						abs_q[i] <= abs_q[i] >> 1;
					end
				end
			end
			// sum of squares
			ST_SQACC: begin
				x_q   <= ((ax_q == 2'd0) ? 64'd0 : x_q) + prod_q[63:0];
				ax_q  <= last_ax ? 2'd0 : ax_q + 2'd1;
				r_q   <= '0;
				cnt_q <= 5'd31;
			end
			// one root digit per cycle
			ST_SQRT: begin
				if (sq_ge) begin
					x_q <= x_q - rb;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
			ST_DECIDE: begin
				ax_q <= '0;
				if (!tick_q && !(!sh_q && m_root == '0)) begin
					budget_q <= scale_now ? '0 : budget_q - m_root[CFG_W-1:0];
				end
			end
			ST_DLOAD: begin
				rem_q <= prod_q[63:32];
				quo_q <= prod_q[31:0];
				cnt_q <= 5'd31;
			end
			// restoring divide, one quotient bit per cycle
			ST_DIV: begin
				rem_q <= dv_ge ? 32'(rp - {1'b0, m_root}) : rp[31:0];
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					vec_q[ax_q] <= vec_q[ax_q][SUM_W-1] ? -SUM_W'(quo_n) : SUM_W'(quo_n);
					ax_q        <= last_ax ? 2'd0 : ax_q + 2'd1;
				end
			end
			ST_ADD: begin
				tot_q[ax_q] <= sat32(50'(tot_q[ax_q]) + 50'(vec_q[ax_q]));
				ax_q        <= last_ax ? 2'd0 : ax_q + 2'd1;
			end
			ST_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_q.new_vel_x <= tot_q[0];
					rsp_q.new_vel_y <= tot_q[1];
					rsp_q.new_vel_z <= tot_q[2];
					for (int i = 0; i < 3; i++) begin
						tot_q[i] <= '0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- sv/pvb_checker.sv -----
// ----------------------------------------------------------------------------
// pvb_checker
// Port-level checks on the velocity blend, attached by bind.
// ----------------------------------------------------------------------------
module pvb_checker
	import pvb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its value
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	// a new result never follows a request in the very next cycle
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!(req_valid && req_ready)))
		else $error("result appeared too soon after a request");

	// a new result is loaded while the block is busy
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while idle");

endmodule

bind prioritized_velocity_blend pvb_checker u_pvb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
